// ===== design/alt_pkg.sv =====
// Package for the associated Legendre table block.
// Holds widths, constants and the sequencer state type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package alt_pkg;
   localparam int MaxOrder = 9;
   localparam logic [63:0] OneQ27 = 64'd1 << 27;
   localparam logic [63:0] TopBit = 64'h8000_0000_0000_0000;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQRT, ST_SEED, ST_MULK, ST_MULX, ST_PREV, ST_SUB, ST_DIV, ST_STORE, ST_EMIT
   } state_type;

   // Turn a sign and a magnitude into a saturated int64.
   function automatic logic [63:0] from_mag(input logic neg, input logic [64:0] mag);
      logic [63:0] res;
      if (neg) res = (mag >= {1'b0, TopBit}) ? TopBit : (64'd0 - mag[63:0]);
      else res = (mag >= {1'b0, TopBit}) ? ~TopBit : mag[63:0];
      return res;
   endfunction
endpackage
`default_nettype wire

// ===== design/assoc_legendre_table.sv =====
// Associated Legendre table generator, top level.
// Depends on alt_pkg; a sequencer runs the datapath, whose 32x33 multiplier is shared.
//
// Usage: present an argument x (Q1.30) on req_arg_x with req_valid. The block
// answers with every P(n,m), 0<=m<=n<=order_max, in row order on the rsp_
// channel, one value per response, last_value marking P(top,top).
// csr_write_enable/csr_write_data set order_max (0 acts as 1, above 9 as 9);
// write it only while idle. Reset sets order_max to 9 and drops any run.
// P(0,0) is presented once the square root is done and the value is stored.
// After the previous value is taken, each later value on the diagonal and in
// row 1 comes from a 64x32 multiply; elsewhere the multiply is followed by a
// 64-step restoring division by n-m, n being the row produced. The block takes
// one request at a time and is not ready until the last value is taken. A
// stalled receiver holds the current value on the rsp_ ports and freezes the
// sequencer.
`timescale 1ns / 1ps
`default_nettype none
module assoc_legendre_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_arg_x,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_degree_n,
   output logic [3:0]       rsp_order_m,
   output logic [63:0]      rsp_poly_value,
   output logic             rsp_last_value,
   input  wire logic        csr_write_enable,
   input  wire logic [3:0]  csr_write_data
);
   import alt_pkg::*;

   state_type state_ff, state_in;
   logic [3:0]  order_ff, order_in;
   logic [3:0]  top_ff, top_in;
   logic [31:0] x_ff, x_in;
   logic [31:0] root_ff, root_in;
   logic [63:0] rem_ff, rem_in;       // sqrt remainder / divider remainder
   logic [5:0]  cnt_ff, cnt_in;
   logic [3:0]  n_ff, n_in, m_ff, m_in;
   logic [63:0] acc_ff, acc_in;       // value under work (magnitude in divider)
   logic [63:0] quo_ff, quo_in;
   logic        neg_ff, neg_in;
   logic [63:0] out_ff, out_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] prev_mem [MaxOrder+1];
   logic [63:0] cur_mem  [MaxOrder+1];
   logic [63:0] nxt_mem  [MaxOrder+1];
   logic        wr_nxt, shift_rows;
   logic [63:0] wr_val;
   logic [3:0]  n1;

   // shared multiplier: 64-bit magnitude times 32-bit magnitude, one half per cycle
   logic [31:0] mul_a;
   logic [32:0] mul_b;
   logic [64:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic [95:0] prod_ff, prod_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_poly_value = out_ff;
   assign rsp_degree_n = n_ff;
   assign rsp_order_m = m_ff;
   assign rsp_last_value = (n_ff == top_ff) && (m_ff == top_ff);
   assign n1 = n_ff - 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         order_ff <= 4'd9;
         root_ff <= 32'd0;
      end else begin
         state_ff <= state_in;
         order_ff <= order_in;
         root_ff <= root_in;
      end
      top_ff <= top_in; x_ff <= x_in; rem_ff <= rem_in;
      cnt_ff <= cnt_in; n_ff <= n_in; m_ff <= m_in; acc_ff <= acc_in;
      quo_ff <= quo_in; neg_ff <= neg_in; out_ff <= out_in;
      a_ff <= a_in; prod_ff <= prod_in;
      if (wr_nxt) nxt_mem[m_ff] <= wr_val;
      if (shift_rows) begin
         prev_mem <= cur_mem;
         cur_mem <= nxt_mem;
      end
   end

   // magnitude helpers
   logic [63:0] cur_v, prev_v, cur_mag, prev_mag;
   logic [3:0]  cur_idx;
   logic [31:0] xm;
   logic [4:0]  k2n1, knm, kd;
   logic [63:0] div_tr;
   logic [64:0] div_sub;
   // the diagonal scales the last entry of the row below
   assign cur_idx = (m_ff == n_ff) ? n1 : m_ff;
   assign cur_v = cur_mem[cur_idx];
   assign prev_v = (m_ff < n1) ? prev_mem[m_ff] : 64'd0;
   assign cur_mag = cur_v[63] ? 64'd0 - cur_v : cur_v;
   assign prev_mag = prev_v[63] ? 64'd0 - prev_v : prev_v;
   assign xm = x_ff[31] ? 32'd0 - x_ff : x_ff;
   assign k2n1 = {n_ff, 1'b0} - 5'd1;     // 2(n-1)+1 for producing row n
   assign knm = {1'b0, n1} + {1'b0, m_ff};
   assign kd = {1'b0, n_ff} - {1'b0, m_ff};

   always_comb begin
      logic [63:0] t;
      logic [64:0] sm;
      logic [64:0] sq_try;
      logic [63:0] sq_bit;
      logic [63:0] xx;
      logic        ov;
      state_in = state_ff; order_in = order_ff; top_in = top_ff; x_in = x_ff;
      root_in = root_ff; rem_in = rem_ff; cnt_in = cnt_ff; n_in = n_ff; m_in = m_ff;
      acc_in = acc_ff; quo_in = quo_ff; neg_in = neg_ff; out_in = out_ff;
      a_in = a_ff; prod_in = prod_ff; wr_nxt = 1'b0; shift_rows = 1'b0; wr_val = 64'd0;
      mul_a = 32'd0; mul_b = 33'd0; t = 64'd0; sm = 65'd0; sq_try = 65'd0;
      sq_bit = 64'd0; xx = 64'd0; ov = 1'b0; div_tr = 64'd0; div_sub = 65'd0;
      if (csr_write_enable) order_in = csr_write_data;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_valid) begin
               x_in = req_arg_x;
               top_in = (order_ff == 4'd0) ? 4'd1 :
                        (order_ff > 4'(MaxOrder)) ? 4'(MaxOrder) : order_ff;
               cnt_in = 6'd0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            // one multiply for x*x, then 31 digit steps of restoring sqrt
            if (cnt_ff == 6'd0) begin
               mul_a = xm; mul_b = {1'b0, xm};
               xx = mul_p[63:0];
               rem_in = (xx >= 64'h1000_0000_0000_0000) ? 64'd0
                        : 64'h1000_0000_0000_0000 - xx;
               acc_in = 64'd0;
               cnt_in = 6'd1;
            end else begin
               // acc holds the partial root scaled by the current digit weight
               sq_bit = 64'd1 << {5'd31 - cnt_ff[4:0], 1'b0};
               sq_try = {1'b0, rem_ff} - ({1'b0, acc_ff} + {1'b0, sq_bit});
               if (!sq_try[64]) begin
                  rem_in = sq_try[63:0];
                  acc_in = (acc_ff >> 1) + sq_bit;
               end else acc_in = acc_ff >> 1;
               if (cnt_ff == 6'd31) begin
                  root_in = acc_in[31:0];
                  n_in = 4'd0; m_in = 4'd0; out_in = OneQ27;
                  state_in = ST_STORE;
               end else cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_SEED, ST_MULK: begin
            // scale current entry by integer k with saturation; row 1 starts from one instead
            if (n_ff == 4'd1) begin
               a_in = OneQ27; neg_in = (m_ff == 4'd0) ? x_ff[31] : 1'b0;
            end else begin
               prod_in = 96'(cur_mag) * 96'(k2n1);
               if (prod_in[95:63] != 33'd0) a_in = cur_v[63] ? TopBit : ~TopBit;
               else a_in = prod_in[63:0];
               neg_in = cur_v[63] ^ ((m_ff == n_ff) ? 1'b0 : x_ff[31]);
            end
            cnt_in = 6'd0;
            state_in = ST_MULX;
         end
         ST_MULX: begin
            // two half products a*b, low half then high half, then round
            mul_a = (cnt_ff == 6'd0) ? a_ff[31:0] : a_ff[63:32];
            mul_b = {1'b0, (m_ff == n_ff) ? root_ff : xm};
            if (cnt_ff == 6'd0) begin
               prod_in = {31'd0, mul_p};
               cnt_in = 6'd1;
            end else if (cnt_ff == 6'd1) begin
               prod_in = prod_ff + {mul_p[63:0], 32'd0};
               cnt_in = 6'd2;
            end else begin
               t = prod_ff[93:30] + {63'd0, prod_ff[29]};
               ov = (prod_ff[95:94] != 2'd0) ||
                    (prod_ff[93:30] == 64'hFFFF_FFFF_FFFF_FFFF && prod_ff[29]);
               acc_in = from_mag(neg_ff & (a_ff != 64'd0 || ov),
                                 ov ? {1'b0, TopBit} + 65'd1 : {1'b0, t});
               if (m_ff == n_ff || n_ff == 4'd1) begin
                  out_in = acc_in; state_in = ST_STORE;
               end else state_in = ST_PREV;
            end
         end
         ST_PREV: begin
            // scale the entry two rows down by n+m-1, saturated
            prod_in = 96'(prev_mag) * 96'(knm);
            t = (prod_in[95:63] != 33'd0) ? TopBit : prod_in[63:0];
            quo_in = from_mag(prev_v[63], {1'b0, t});
            state_in = ST_SUB;
         end
         ST_SUB: begin
            sm = {acc_ff[63], acc_ff} - {quo_ff[63], quo_ff};
            if (sm[64] != sm[63]) t = sm[64] ? TopBit : ~TopBit;
            else t = sm[63:0];
            neg_in = t[63];
            acc_in = t[63] ? 64'd0 - t : t;
            quo_in = 64'd0; rem_in = 64'd0; cnt_in = 6'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring division by n-m, one quotient bit per cycle
            div_tr = {rem_ff[62:0], acc_ff[6'd63 - cnt_ff]};
            div_sub = {1'b0, div_tr} - {60'd0, kd};
            if (!div_sub[64]) begin
               rem_in = div_sub[63:0]; quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = div_tr; quo_in = {quo_ff[62:0], 1'b0};
            end
            if (cnt_ff == 6'd63) begin
               out_in = from_mag(neg_ff, {1'b0, quo_in});
               state_in = ST_STORE;
            end else cnt_in = cnt_ff + 6'd1;
         end
         ST_STORE: begin
            wr_nxt = 1'b1; wr_val = out_ff;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (n_ff == top_ff && m_ff == top_ff) state_in = ST_IDLE;
               else if (m_ff == n_ff) begin
                  // advance the rows at the end of each row but the last, row 0 included
                  shift_rows = 1'b1;
                  n_in = n_ff + 4'd1; m_in = 4'd0;
                  state_in = ST_SEED;
               end else begin
                  m_in = m_ff + 4'd1;
                  state_in = ST_MULK;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== sim/assoc_legendre_table_tb.sv =====
// Testbench for assoc_legendre_table: drives arguments under several order settings
// and idle patterns, and checks every P(n,m) against a fixed-point predictor.
// Depends on alt_pkg (MaxOrder, OneQ27) and the assoc_legendre_table RTL.
`timescale 1ns / 1ps

typedef struct packed {
   logic [3:0]  degree_n;
   logic [3:0]  order_m;
   logic [63:0] poly_value;
   logic        last_value;
} legendre_entry_type;

class legendre_scoreboard;
   legendre_entry_type entries_due[$];
   int unsigned     mismatches;

   function new();
      mismatches = 0;
   endfunction

   static function logic [63:0] magnitude(logic [63:0] a);
      return a[63] ? (64'd0 - a) : a;
   endfunction

   static function logic [63:0] saturate(bit neg, logic [127:0] mag);
      if (mag >= (128'd1 << 63)) return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      return neg ? (64'd0 - mag[63:0]) : mag[63:0];
   endfunction

   // a * b / 2^30, magnitude rounded half away from zero
   static function logic [63:0] mul_frac(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = 128'(magnitude(a)) * 128'(magnitude(b)) + (128'd1 << 29);
      return saturate(a[63] != b[63], prod >> 30);
   endfunction

   static function logic [63:0] mul_int(logic [63:0] a, int unsigned k);
      return saturate(a[63], 128'(magnitude(a)) * 128'(k));
   endfunction

   static function logic [63:0] sub_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] d;
      d = {a[63], a} - {b[63], b};
      if (d[64] != d[63]) return d[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      return d[63:0];
   endfunction

   static function logic [63:0] div_int(logic [63:0] a, int unsigned d);
      return saturate(a[63], 128'(magnitude(a) / 64'(d)));
   endfunction

   static function logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits = bits >> 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v = v - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   function void push_entry(int n, int m, logic [63:0] v, int top);
      legendre_entry_type e;
      e.degree_n = n[3:0];
      e.order_m = m[3:0];
      e.poly_value = v;
      e.last_value = (n == top) && (m == top);
      entries_due.push_back(e);
   endfunction

   // Build the whole expected table for one accepted request.
   function void note_request(logic [31:0] arg, logic [3:0] order_reg);
      logic [63:0] x, xx, root, one;
      logic [63:0] prev_row[alt_pkg::MaxOrder+1];
      logic [63:0] cur_row[alt_pkg::MaxOrder+1];
      logic [63:0] next_row[alt_pkg::MaxOrder+1];
      logic [63:0] a, b;
      int top;
      one = alt_pkg::OneQ27;
      top = order_reg;
      if (top < 1) top = 1;
      if (top > alt_pkg::MaxOrder) top = alt_pkg::MaxOrder;
      x = {{32{arg[31]}}, arg};
      xx = magnitude(x) * magnitude(x);
      root = (xx >= (64'd1 << 60)) ? 64'd0 : floor_sqrt((64'd1 << 60) - xx);
      for (int i = 0; i <= alt_pkg::MaxOrder; i++) begin
         prev_row[i] = 0;
         cur_row[i] = 0;
      end
      prev_row[0] = one;
      push_entry(0, 0, one, top);
      cur_row[0] = mul_frac(one, x);
      cur_row[1] = mul_frac(one, root);
      push_entry(1, 0, cur_row[0], top);
      push_entry(1, 1, cur_row[1], top);
      for (int n = 1; n < top; n++) begin
         for (int i = 0; i <= alt_pkg::MaxOrder; i++) next_row[i] = 0;
         for (int m = 0; m <= n; m++) begin
            a = mul_frac(mul_int(cur_row[m], 2 * n + 1), x);
            b = mul_int(prev_row[m], n + m);
            next_row[m] = div_int(sub_sat(a, b), n - m + 1);
         end
         next_row[n+1] = mul_frac(mul_int(cur_row[n], 2 * n + 1), root);
         prev_row = cur_row;
         cur_row = next_row;
         for (int m = 0; m <= n + 1; m++) push_entry(n + 1, m, cur_row[m], top);
      end
   endfunction

   function void check_result(legendre_entry_type got);
      legendre_entry_type want;
      if (entries_due.size() == 0) begin
         $error("unexpected value n=%0d m=%0d", got.degree_n, got.order_m);
         mismatches++;
         return;
      end
      want = entries_due.pop_front();
      if (got.degree_n !== want.degree_n) begin
         $error("degree_n: expected %0d, got %0d", want.degree_n, got.degree_n);
         mismatches++;
      end
      if (got.order_m !== want.order_m) begin
         $error("order_m: expected %0d, got %0d", want.order_m, got.order_m);
         mismatches++;
      end
      if (got.poly_value !== want.poly_value) begin
         $error("poly_value: expected %h, got %h", want.poly_value, got.poly_value);
         mismatches++;
      end
      if (got.last_value !== want.last_value) begin
         $error("last_value: expected %0d, got %0d", want.last_value, got.last_value);
         mismatches++;
      end
   endfunction
endclass

module assoc_legendre_table_tb;
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_arg_x;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_degree_n;
   logic [3:0]  rsp_order_m;
   logic [63:0] rsp_poly_value;
   logic        rsp_last_value;
   logic        csr_write_enable;
   logic [3:0]  csr_write_data;

   legendre_scoreboard table_sb;
   logic [3:0]  order_setting;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   assoc_legendre_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_arg_x(req_arg_x),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_degree_n(rsp_degree_n), .rsp_order_m(rsp_order_m),
      .rsp_poly_value(rsp_poly_value), .rsp_last_value(rsp_last_value),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #160_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      rsp_ready = 1;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         table_sb.check_result({rsp_degree_n, rsp_order_m, rsp_poly_value, rsp_last_value});
   end

   task automatic send_request(logic [31:0] arg);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_arg_x <= arg;
      do @(posedge clock); while (!req_ready);
      table_sb.note_request(arg, order_setting);
   endtask

   // Drop valid and wait until the table of every request has come back.
   task automatic drain;
      @(negedge clock);
      req_valid <= 0;
      while (table_sb.entries_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_order(logic [3:0] value);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 0;
      order_setting = value;
   endtask

   function automatic logic [31:0] random_arg();
      int unsigned pick;
      longint v;
      pick = $urandom_range(99);
      if (pick < 70) begin
         v = longint'($urandom_range(32'h8000_0000, 0)) - (64'sd1 << 30);
         return v[31:0];
      end
      if (pick < 85) return $urandom;
      case ($urandom_range(5))
         0: return 32'h4000_0000;
         1: return 32'hC000_0000;
         2: return 32'h0000_0000;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         default: return 32'(int'($urandom_range(16)) - 8);
      endcase
   endfunction

   logic [31:0] directed_args[] = '{
      32'h0000_0000, 32'h4000_0000, 32'hC000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0001, 32'hBFFF_FFFF, 32'h2000_0000,
      32'hE000_0000, 32'h2D41_3CCD, 32'hAAAA_AAAA, 32'h5555_5555, 32'h3FFF_FFFF,
      32'hC000_0001, 32'h0800_0000, 32'hF000_0000
   };
   logic [3:0] phase_orders[] = '{4'd0, 4'd15, 4'd1, 4'd2, 4'd3, 4'd9, 4'd4, 4'd10};

   initial begin
      table_sb = new();
      reset = 1;
      req_valid = 0;
      req_arg_x = 0;
      csr_write_enable = 0;
      csr_write_data = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      order_setting = 4'd9;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (directed_args[i]) send_request(directed_args[i]);
      drain();

      for (int p = 0; p < 8; p++) begin
         write_order(p == 7 ? 4'($urandom_range(15)) : phase_orders[p]);
         send_idle_pct = (p % 4 == 1) ? 77 : (p % 4 == 3) ? 23 : 0;
         recv_stall_pct = (p % 4 == 2) ? 77 : (p % 4 == 3) ? 23 : 0;
         repeat (17) send_request(random_arg());
         drain();
      end

      if (table_sb.mismatches == 0 && table_sb.entries_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
